### rtl/core/llcp_pdu_deframer_macros.svh
// Assertion macros shared by the LLCP deframer RTL.
`ifndef LLCP_PDU_DEFRAMER_MACROS_SVH
`define LLCP_PDU_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define LLCP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on aclk outside of reset.
`define LLCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/llcp_pkg.sv
// Types, codes and helpers for the LLCP PDU deframer.
package llcp_pkg;

    // Parser position within a frame
    typedef enum logic [3:0] {
        PH_H0       = 4'd0,
        PH_H1       = 4'd1,
        PH_SEQ      = 4'd2,
        PH_INFO     = 4'd3,
        PH_LEN_H    = 4'd4,
        PH_LEN_L    = 4'd5,
        PH_SUB_H0   = 4'd6,
        PH_SUB_H1   = 4'd7,
        PH_SUB_SEQ  = 4'd8,
        PH_SUB_INFO = 4'd9,
        PH_DROP     = 4'd10
    } phase_t;

    // Result item kinds
    typedef enum logic [1:0] {
        KIND_HDR  = 2'd0,
        KIND_INFO = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_LEN         = 3'd1,
        ST_OVERRUN     = 3'd2,
        ST_SHORT_SUB   = 3'd3,
        ST_SHORT_FRAME = 3'd4,
        ST_BAD_AGF     = 3'd5
    } status_t;

    // PDU type codes of interest
    localparam logic [3:0] PT_AGF = 4'd2;
    localparam logic [3:0] PT_I   = 4'd12;
    localparam logic [3:0] PT_RR  = 4'd13;
    localparam logic [3:0] PT_RNR = 4'd14;

    // Smallest legal sub-PDU length (two header bytes)
    localparam logic [15:0] MIN_SUB_LEN = 16'd2;

    // Types that carry a sequence byte
    function automatic logic type_has_seq(input logic [3:0] t);
        return t inside {PT_I, PT_RR, PT_RNR};
    endfunction

endpackage

### rtl/core/llcp_pdu_deframer.sv
// LLCP PDU deframer: byte-serial header decode and AGF splitting.
//
// Usage: frame bytes enter on the s_ channel (s_data_byte, s_frame_end on
// the last byte of a frame). Each transfer yields zero or one result on the
// m_ channel: a header record once the header (and sequence byte, for I, RR
// and RNR) is complete, one item per information byte, or an error-only
// item. Errors end the PDU; remaining bytes of the frame are dropped.
// The cfg_ channel writes split_aggregates (1 = split AGF frames); it is
// always ready and should be written only while the block is idle.
// Output: a result is registered and appears on m_ in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the output is not stalled; all decoding is a
// single pass from the state registers and the incoming byte into the output register.
// Stall: the output register holds its result while m_ready is low, and
// s_ready drops then, so no transfer is lost; s_ready is high whenever the
// output register is empty or being drained in the same cycle.
// Reset: synchronous, active low; the parser waits for the first byte of a
// new frame, no result is pending, split_aggregates returns to 1.
`include "llcp_pdu_deframer_macros.svh"

module llcp_pdu_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    // config write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_split_aggregates,
    // byte input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_frame_end,
    // result output
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [5:0] m_dsap,
    output logic [3:0] m_ptype,
    output logic [5:0] m_ssap,
    output logic       m_has_sequence,
    output logic [3:0] m_send_seq,
    output logic [3:0] m_recv_seq,
    output logic [7:0] m_info_byte,
    output logic       m_from_aggregate,
    output logic       m_last_of_pdu,
    output logic [2:0] m_status
);
    import llcp_pkg::*;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  fhb_reg, fhb_next;
    logic [3:0]  type_reg, type_next;
    logic [5:0]  ssap_reg, ssap_next;
    logic        in_agg_reg, in_agg_next;
    logic [7:0]  len_high_reg, len_high_next;
    logic [15:0] sub_rem_reg, sub_rem_next;
    logic        split_reg;

    // Output register
    logic        m_valid_reg, m_valid_next;
    kind_t       kind_reg;
    logic [5:0]  dsap_reg;
    logic [3:0]  ptype_reg;
    logic [5:0]  ssap_out_reg;
    logic        seq_reg;
    logic [3:0]  ns_reg, nr_reg;
    logic [7:0]  info_reg;
    logic        from_agg_reg;
    logic        last_reg;
    status_t     status_reg;

    // Item being built this cycle
    logic        emit_en;
    kind_t       e_kind;
    logic        e_hdr;
    logic [3:0]  e_ns, e_nr;
    logic [7:0]  e_info;
    logic        e_last;
    status_t     e_status;
    logic        e_seq;

    logic        s_fire;
    logic        fe;
    logic [7:0]  b;
    logic [3:0]  type_dec;
    logic [15:0] rem_dec;
    logic [15:0] len_full;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign fe        = s_frame_end;
    assign b         = s_data_byte;
    assign type_dec  = {fhb_reg[1:0], b[7:6]};
    assign rem_dec   = sub_rem_reg - 16'd1;
    assign len_full  = {len_high_reg, b};

    // Byte decode and next state
    always_comb begin
        phase_next    = phase_reg;
        fhb_next      = fhb_reg;
        type_next     = type_reg;
        ssap_next     = ssap_reg;
        in_agg_next   = in_agg_reg;
        len_high_next = len_high_reg;
        sub_rem_next  = sub_rem_reg;
        emit_en       = 1'b0;
        e_kind        = KIND_HDR;
        e_hdr         = 1'b0;
        e_ns          = 4'd0;
        e_nr          = 4'd0;
        e_info        = 8'd0;
        e_last        = 1'b0;
        e_status      = ST_OK;
        if (s_fire) begin
            case (phase_reg)
                PH_H0: begin
                    in_agg_next = 1'b0;
                    fhb_next    = b;
                    if (fe) begin
                        emit_en    = 1'b1;
                        e_kind     = KIND_ERR;
                        e_last     = 1'b1;
                        e_status   = ST_SHORT_FRAME;
                        phase_next = PH_H0;
                    end else begin
                        phase_next = PH_H1;
                    end
                end
                PH_H1: begin
                    type_next = type_dec;
                    ssap_next = b[5:0];
                    if (type_dec == PT_AGF && split_reg) begin
                        if (fhb_reg[7:2] == 6'd0 && b[5:0] == 6'd0) begin
                            in_agg_next = 1'b1;
                            phase_next  = fe ? PH_H0 : PH_LEN_H;
                        end else begin
                            emit_en    = 1'b1;
                            e_kind     = KIND_ERR;
                            e_last     = 1'b1;
                            e_status   = ST_BAD_AGF;
                            phase_next = fe ? PH_H0 : PH_DROP;
                        end
                    end else if (type_has_seq(type_dec)) begin
                        if (fe) begin
                            emit_en    = 1'b1;
                            e_kind     = KIND_ERR;
                            e_last     = 1'b1;
                            e_status   = ST_SHORT_FRAME;
                            phase_next = PH_H0;
                        end else begin
                            phase_next = PH_SEQ;
                        end
                    end else begin
                        emit_en    = 1'b1;
                        e_kind     = KIND_HDR;
                        e_hdr      = 1'b1;
                        e_last     = fe;
                        phase_next = fe ? PH_H0 : PH_INFO;
                    end
                end
                PH_SEQ: begin
                    emit_en    = 1'b1;
                    e_kind     = KIND_HDR;
                    e_hdr      = 1'b1;
                    e_ns       = b[7:4];
                    e_nr       = b[3:0];
                    e_last     = fe;
                    phase_next = fe ? PH_H0 : PH_INFO;
                end
                PH_INFO: begin
                    emit_en    = 1'b1;
                    e_kind     = KIND_INFO;
                    e_hdr      = 1'b1;
                    e_info     = b;
                    e_last     = fe;
                    phase_next = fe ? PH_H0 : PH_INFO;
                end
                PH_LEN_H: begin
                    len_high_next = b;
                    if (fe) begin
                        emit_en    = 1'b1;
                        e_kind     = KIND_ERR;
                        e_last     = 1'b1;
                        e_status   = ST_LEN;
                        phase_next = PH_H0;
                    end else begin
                        phase_next = PH_LEN_L;
                    end
                end
                PH_LEN_L: begin
                    sub_rem_next = len_full;
                    if (len_full < MIN_SUB_LEN) begin
                        emit_en    = 1'b1;
                        e_kind     = KIND_ERR;
                        e_last     = 1'b1;
                        e_status   = ST_SHORT_SUB;
                        phase_next = fe ? PH_H0 : PH_DROP;
                    end else if (fe) begin
                        emit_en    = 1'b1;
                        e_kind     = KIND_ERR;
                        e_last     = 1'b1;
                        e_status   = ST_OVERRUN;
                        phase_next = PH_H0;
                    end else begin
                        phase_next = PH_SUB_H0;
                    end
                end
                PH_SUB_H0: begin
                    fhb_next     = b;
                    sub_rem_next = rem_dec;
                    if (fe) begin
                        emit_en    = 1'b1;
                        e_kind     = KIND_ERR;
                        e_last     = 1'b1;
                        e_status   = ST_OVERRUN;
                        phase_next = PH_H0;
                    end else begin
                        phase_next = PH_SUB_H1;
                    end
                end
                PH_SUB_H1, PH_SUB_SEQ, PH_SUB_INFO: begin
                    sub_rem_next = rem_dec;
                    if (phase_reg == PH_SUB_H1) begin
                        type_next = type_dec;
                        ssap_next = b[5:0];
                    end
                    if (phase_reg == PH_SUB_H1 && type_has_seq(type_dec)) begin
                        // sequence byte still to come
                        if (rem_dec == 16'd0) begin
                            emit_en    = 1'b1;
                            e_kind     = KIND_ERR;
                            e_last     = 1'b1;
                            e_status   = ST_SHORT_SUB;
                            phase_next = fe ? PH_H0 : PH_DROP;
                        end else if (fe) begin
                            emit_en    = 1'b1;
                            e_kind     = KIND_ERR;
                            e_last     = 1'b1;
                            e_status   = ST_OVERRUN;
                            phase_next = PH_H0;
                        end else begin
                            phase_next = PH_SUB_SEQ;
                        end
                    end else begin
                        // header or information item of a sub-PDU
                        emit_en = 1'b1;
                        e_hdr   = 1'b1;
                        e_kind  = (phase_reg == PH_SUB_INFO) ? KIND_INFO : KIND_HDR;
                        if (phase_reg == PH_SUB_SEQ) begin
                            e_ns = b[7:4];
                            e_nr = b[3:0];
                        end
                        if (phase_reg == PH_SUB_INFO) begin
                            e_info = b;
                        end
                        if (rem_dec == 16'd0) begin
                            e_last     = 1'b1;
                            phase_next = fe ? PH_H0 : PH_LEN_H;
                        end else if (fe) begin
                            e_last     = 1'b1;
                            e_status   = ST_OVERRUN;
                            phase_next = PH_H0;
                        end else begin
                            phase_next = PH_SUB_INFO;
                        end
                    end
                end
                PH_DROP: begin
                    if (fe) begin
                        phase_next = PH_H0;
                    end
                end
                default: begin
                    phase_next = PH_H0;
                end
            endcase
        end
    end

    assign e_seq        = e_hdr && type_has_seq(type_next);
    assign m_valid_next = (s_fire && emit_en) || (m_valid_reg && !m_ready);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_H0;
            fhb_reg      <= 8'd0;
            type_reg     <= 4'd0;
            ssap_reg     <= 6'd0;
            in_agg_reg   <= 1'b0;
            len_high_reg <= 8'd0;
            sub_rem_reg  <= 16'd0;
            split_reg    <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            fhb_reg      <= fhb_next;
            type_reg     <= type_next;
            ssap_reg     <= ssap_next;
            in_agg_reg   <= in_agg_next;
            len_high_reg <= len_high_next;
            sub_rem_reg  <= sub_rem_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                split_reg <= cfg_split_aggregates;
            end
        end
    end

    // Result payload, loaded when a new item is produced
    always_ff @(posedge aclk) begin
        if (s_fire && emit_en) begin
            kind_reg     <= e_kind;
            dsap_reg     <= e_hdr ? fhb_next[7:2] : 6'd0;
            ptype_reg    <= e_hdr ? type_next : 4'd0;
            ssap_out_reg <= e_hdr ? ssap_next : 6'd0;
            seq_reg      <= e_seq;
            ns_reg       <= e_seq ? e_ns : 4'd0;
            nr_reg       <= e_seq ? e_nr : 4'd0;
            info_reg     <= e_info;
            from_agg_reg <= in_agg_next;
            last_reg     <= e_last;
            status_reg   <= e_status;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_dsap           = dsap_reg;
    assign m_ptype          = ptype_reg;
    assign m_ssap           = ssap_out_reg;
    assign m_has_sequence   = seq_reg;
    assign m_send_seq       = ns_reg;
    assign m_recv_seq       = nr_reg;
    assign m_info_byte      = info_reg;
    assign m_from_aggregate = from_agg_reg;
    assign m_last_of_pdu    = last_reg;
    assign m_status         = status_reg;

    // Checks
    `LLCP_ASSERT_SAME(a_err_item_ends_pdu,
        m_valid_reg && kind_reg == KIND_ERR,
        last_reg && status_reg != ST_OK,
        "error-only item without last mark or status")
    `LLCP_ASSERT_SAME(a_status_ends_pdu,
        m_valid_reg && status_reg != ST_OK,
        last_reg,
        "error status on an item that does not end the PDU")
    // info items of I, RR and RNR keep the sequence flag but carry no numbers
    `LLCP_ASSERT_SAME(a_seq_numbers_on_header,
        m_valid_reg && kind_reg != KIND_HDR,
        ns_reg == 4'd0 && nr_reg == 4'd0,
        "sequence numbers on a non-header item")
    `LLCP_ASSERT_NEXT(a_frame_end_resyncs,
        s_fire && s_frame_end,
        phase_reg == PH_H0,
        "parser not back at frame start after frame end")

endmodule

### verif/llcp_result_checker.sv
// Result checker for the LLCP PDU deframer: predicts each result and compares.
module llcp_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_split_aggregates,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [5:0]  m_dsap,
    input  logic [3:0]  m_ptype,
    input  logic [5:0]  m_ssap,
    input  logic        m_has_sequence,
    input  logic [3:0]  m_send_seq,
    input  logic [3:0]  m_recv_seq,
    input  logic [7:0]  m_info_byte,
    input  logic        m_from_aggregate,
    input  logic        m_last_of_pdu,
    input  logic [2:0]  m_status,
    output int unsigned n_pending,
    output int unsigned n_bad
);
    timeunit 1ns;
    timeprecision 1ps;

    import llcp_pkg::*;

    // One result item, fields in port order
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] dsap;
        logic [3:0] ptype;
        logic [5:0] ssap;
        logic       has_sequence;
        logic [3:0] send_seq;
        logic [3:0] recv_seq;
        logic [7:0] info_byte;
        logic       from_aggregate;
        logic       last_of_pdu;
        logic [2:0] status;
    } pdu_item_t;

    // Parser state mirror
    logic        split_on;
    logic [3:0]  ph;
    logic [7:0]  hdr_byte0;
    logic [3:0]  cur_type;
    logic [5:0]  cur_ssap;
    logic        in_agg;
    logic [7:0]  len_hi;
    logic [15:0] sub_left;

    pdu_item_t   due_items[$];
    pdu_item_t   got, due, fresh;
    int unsigned bad_cnt = 0;

    function automatic bit carries_seq(input logic [3:0] t);
        return (t == PT_I) || (t == PT_RR) || (t == PT_RNR);
    endfunction

    // Build an item from the current PDU context
    function automatic pdu_item_t make_item(input kind_t k, input bit hdr,
                                            input logic [3:0] ns, input logic [3:0] nr,
                                            input logic [7:0] info, input bit last,
                                            input status_t st);
        pdu_item_t it;
        bit        sq;
        sq                = hdr && carries_seq(cur_type);
        it.kind           = k;
        it.dsap           = hdr ? hdr_byte0[7:2] : 6'd0;
        it.ptype          = hdr ? cur_type : 4'd0;
        it.ssap           = hdr ? cur_ssap : 6'd0;
        it.has_sequence   = sq;
        it.send_seq       = sq ? ns : 4'd0;
        it.recv_seq       = sq ? nr : 4'd0;
        it.info_byte      = info;
        it.from_aggregate = in_agg;
        it.last_of_pdu    = last;
        it.status         = st;
        return it;
    endfunction

    // Error ends the frame; rest of the frame is dropped unless this was its end
    function automatic pdu_item_t abort_pdu(input status_t st, input bit fe);
        ph = fe ? PH_H0 : PH_DROP;
        return make_item(KIND_ERR, 1'b0, 4'd0, 4'd0, 8'd0, 1'b1, st);
    endfunction

    // Header or info item of a sub-PDU, after its byte was counted
    function automatic pdu_item_t sub_result(input kind_t k, input logic [3:0] ns,
                                             input logic [3:0] nr, input logic [7:0] info,
                                             input bit fe);
        pdu_item_t it;
        if (sub_left == 16'd0) begin
            it = make_item(k, 1'b1, ns, nr, info, 1'b1, ST_OK);
            ph = fe ? PH_H0 : PH_LEN_H;
        end else if (fe) begin
            it = make_item(k, 1'b1, ns, nr, info, 1'b1, ST_OVERRUN);
            ph = PH_H0;
        end else begin
            it = make_item(k, 1'b1, ns, nr, info, 1'b0, ST_OK);
            ph = PH_SUB_INFO;
        end
        return it;
    endfunction

    // Advance the parser by one byte; returns 1 when the byte yields a result
    function automatic bit parse_byte(input logic [7:0] b, input bit fe,
                                      output pdu_item_t it);
        it = '0;
        case (ph)
            PH_H0: begin
                in_agg    = 1'b0;
                hdr_byte0 = b;
                if (fe) begin
                    it = abort_pdu(ST_SHORT_FRAME, 1'b1);
                    return 1'b1;
                end
                ph = PH_H1;
                return 1'b0;
            end
            PH_H1: begin
                cur_type = {hdr_byte0[1:0], b[7:6]};
                cur_ssap = b[5:0];
                if (cur_type == PT_AGF && split_on) begin
                    if (hdr_byte0[7:2] == 6'd0 && cur_ssap == 6'd0) begin
                        in_agg = 1'b1;
                        ph     = fe ? PH_H0 : PH_LEN_H;
                        return 1'b0;
                    end
                    it = abort_pdu(ST_BAD_AGF, fe);
                    return 1'b1;
                end
                if (carries_seq(cur_type)) begin
                    if (fe) begin
                        it = abort_pdu(ST_SHORT_FRAME, 1'b1);
                        return 1'b1;
                    end
                    ph = PH_SEQ;
                    return 1'b0;
                end
                it = make_item(KIND_HDR, 1'b1, 4'd0, 4'd0, 8'd0, fe, ST_OK);
                ph = fe ? PH_H0 : PH_INFO;
                return 1'b1;
            end
            PH_SEQ: begin
                it = make_item(KIND_HDR, 1'b1, b[7:4], b[3:0], 8'd0, fe, ST_OK);
                ph = fe ? PH_H0 : PH_INFO;
                return 1'b1;
            end
            PH_INFO: begin
                it = make_item(KIND_INFO, 1'b1, 4'd0, 4'd0, b, fe, ST_OK);
                ph = fe ? PH_H0 : PH_INFO;
                return 1'b1;
            end
            PH_LEN_H: begin
                len_hi = b;
                if (fe) begin
                    it = abort_pdu(ST_LEN, 1'b1);
                    return 1'b1;
                end
                ph = PH_LEN_L;
                return 1'b0;
            end
            PH_LEN_L: begin
                sub_left = {len_hi, b};
                if (sub_left < 16'd2) begin
                    it = abort_pdu(ST_SHORT_SUB, fe);
                    return 1'b1;
                end
                if (fe) begin
                    it = abort_pdu(ST_OVERRUN, 1'b1);
                    return 1'b1;
                end
                ph = PH_SUB_H0;
                return 1'b0;
            end
            PH_SUB_H0: begin
                hdr_byte0 = b;
                sub_left  = sub_left - 16'd1;
                if (fe) begin
                    it = abort_pdu(ST_OVERRUN, 1'b1);
                    return 1'b1;
                end
                ph = PH_SUB_H1;
                return 1'b0;
            end
            PH_SUB_H1: begin
                cur_type = {hdr_byte0[1:0], b[7:6]};
                cur_ssap = b[5:0];
                sub_left = sub_left - 16'd1;
                // nested AGF falls through as a plain sub-PDU
                if (carries_seq(cur_type)) begin
                    if (sub_left == 16'd0) begin
                        it = abort_pdu(ST_SHORT_SUB, fe);
                        return 1'b1;
                    end
                    if (fe) begin
                        it = abort_pdu(ST_OVERRUN, 1'b1);
                        return 1'b1;
                    end
                    ph = PH_SUB_SEQ;
                    return 1'b0;
                end
                it = sub_result(KIND_HDR, 4'd0, 4'd0, 8'd0, fe);
                return 1'b1;
            end
            PH_SUB_SEQ: begin
                sub_left = sub_left - 16'd1;
                it = sub_result(KIND_HDR, b[7:4], b[3:0], 8'd0, fe);
                return 1'b1;
            end
            PH_SUB_INFO: begin
                sub_left = sub_left - 16'd1;
                it = sub_result(KIND_INFO, 4'd0, 4'd0, b, fe);
                return 1'b1;
            end
            PH_DROP: begin
                if (fe)
                    ph = PH_H0;
                return 1'b0;
            end
            default: begin
                ph = PH_H0;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic string show(input pdu_item_t it);
        return $sformatf({"kind=%0d dsap=%0d ptype=%0d ssap=%0d seq=%0b ns=%0d nr=%0d",
                          " info=%02h agg=%0b last=%0b st=%0d"},
                         it.kind, it.dsap, it.ptype, it.ssap, it.has_sequence,
                         it.send_seq, it.recv_seq, it.info_byte, it.from_aggregate,
                         it.last_of_pdu, it.status);
    endfunction

    // Only the first few failures are printed
    task automatic flag(input string msg);
        bad_cnt++;
        if (bad_cnt <= 10)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    // Compare outgoing transfers first, then fold in config and incoming bytes
    always @(posedge aclk) begin
        if (!aresetn) begin
            split_on  = 1'b1;
            ph        = PH_H0;
            hdr_byte0 = 8'd0;
            cur_type  = 4'd0;
            cur_ssap  = 6'd0;
            in_agg    = 1'b0;
            len_hi    = 8'd0;
            sub_left  = 16'd0;
            due_items.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_dsap, m_ptype, m_ssap, m_has_sequence, m_send_seq,
                       m_recv_seq, m_info_byte, m_from_aggregate, m_last_of_pdu, m_status};
                if (due_items.size() == 0) begin
                    flag({"result with nothing expected: ", show(got)});
                end else begin
                    due = due_items.pop_front();
                    if (got !== due)
                        flag({"result differs\n  expected ", show(due),
                              "\n  actual   ", show(got)});
                end
            end
            if (cfg_valid && cfg_ready)
                split_on = cfg_split_aggregates;
            if (s_valid && s_ready) begin
                if (parse_byte(s_data_byte, s_frame_end, fresh))
                    due_items.push_back(fresh);
            end
        end
        n_pending <= unsigned'(due_items.size());
        n_bad     <= bad_cnt;
    end

endmodule

### verif/tb_top.sv
// Testbench top for the LLCP PDU deframer: frame stimulus, flow control, verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import llcp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASE_BYTES  = 225;
    localparam int unsigned PHASE_COUNT  = 6;

    logic        aclk                 = 1'b0;
    logic        aresetn              = 1'b0;
    logic        cfg_valid            = 1'b0;
    logic        cfg_split_aggregates = 1'b0;
    logic        s_valid              = 1'b0;
    logic [7:0]  s_data_byte          = 8'd0;
    logic        s_frame_end          = 1'b0;
    logic        m_ready              = 1'b0;
    logic        cfg_ready;
    logic        s_ready;
    logic        m_valid;
    logic [1:0]  m_kind;
    logic [5:0]  m_dsap;
    logic [3:0]  m_ptype;
    logic [5:0]  m_ssap;
    logic        m_has_sequence;
    logic [3:0]  m_send_seq;
    logic [3:0]  m_recv_seq;
    logic [7:0]  m_info_byte;
    logic        m_from_aggregate;
    logic        m_last_of_pdu;
    logic [2:0]  m_status;
    int unsigned n_pending;
    int unsigned n_bad;

    // Stimulus state
    logic [7:0]  frm[$];
    int unsigned sent = 0;
    int unsigned rx_wait = 0;
    bit          tx_fast = 1'b0;
    bit          rx_fast = 1'b0;

    llcp_pdu_deframer dut (.*);

    llcp_result_checker u_check (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Receiver: random stall before each result transfer
    always @(posedge aclk) begin
        if (m_valid && m_ready)
            rx_wait = rx_fast ? 0 : $urandom_range(0, 8);
        else if (rx_wait != 0)
            rx_wait--;
        m_ready <= (rx_wait == 0);
    end

    // One byte transfer, after a random gap
    task automatic push_byte(input logic [7:0] b, input bit fe);
        int unsigned gap;
        gap = tx_fast ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_frame_end <= fe;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frm.size(); i++)
            push_byte(frm[i], i == frm.size() - 1);
    endtask

    // Wait until every expected result has come and the parser is quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_split(input bit v);
        settle();
        cfg_valid            <= 1'b1;
        cfg_split_aggregates <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [3:0] pick_type();
        if ($urandom_range(0, 9) < 4) begin
            case ($urandom_range(0, 2))
                0: return PT_I;
                1: return PT_RR;
                default: return PT_RNR;
            endcase
        end
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic bit seq_type(input logic [3:0] t);
        return (t == PT_I) || (t == PT_RR) || (t == PT_RNR);
    endfunction

    // Append one PDU: header, sequence byte if its type has one, info bytes
    function automatic void put_pdu(input logic [5:0] d, input logic [3:0] t,
                                    input logic [5:0] s, input int unsigned n_info);
        frm.push_back({d, t[3:2]});
        frm.push_back({t[1:0], s});
        if (seq_type(t))
            frm.push_back(8'($urandom_range(0, 255)));
        repeat (n_info) frm.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [5:0] pick_sap();
        case ($urandom_range(0, 5))
            0: return 6'd0;
            1: return 6'd63;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic void build_plain();
        put_pdu(pick_sap(), pick_type(), pick_sap(), $urandom_range(0, 6));
    endfunction

    // Well-formed aggregate with zero to three length-prefixed sub-PDUs
    function automatic void build_aggregate();
        logic [3:0]  t;
        int unsigned n, len;
        frm.push_back(8'h00);
        frm.push_back(8'h80);
        repeat ($urandom_range(0, 3)) begin
            t   = pick_type();
            n   = $urandom_range(0, 4);
            len = 2 + (seq_type(t) ? 1 : 0) + n;
            frm.push_back(8'(len >> 8));
            frm.push_back(8'(len));
            put_pdu(pick_sap(), t, pick_sap(), n);
        end
    endfunction

    // Mostly well-formed frames; the rest truncated, corrupted or pure noise
    function automatic void build_frame();
        int unsigned sel, keep;
        frm.delete();
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            build_plain();
        end else if (sel < 75) begin
            build_aggregate();
        end else begin
            if ($urandom_range(0, 1) != 0)
                build_aggregate();
            else
                build_plain();
            case ($urandom_range(0, 2))
                0: begin
                    keep = $urandom_range(1, frm.size());
                    while (frm.size() > keep) void'(frm.pop_back());
                end
                1: frm[$urandom_range(0, frm.size() - 1)] = 8'($urandom_range(0, 255));
                default: begin
                    frm.delete();
                    repeat ($urandom_range(1, 8)) frm.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endfunction

    // Run-away guard
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned goal;
        bit          paused;
        paused = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames, splitting on from reset
        frm = '{8'hFF};                         // frame ends on first header byte
        send_frame();
        frm = '{8'hFF, 8'h00};                  // I header cut before sequence byte
        send_frame();
        frm = '{8'h07, 8'h3F, 8'hA5, 8'hFF};    // I with sequence and one info byte
        send_frame();
        frm = '{8'h00, 8'h80};                  // empty aggregate
        send_frame();
        frm = '{8'h04, 8'h80, 8'h55};           // AGF with nonzero dsap, tail dropped
        send_frame();
        // RR sub-PDU, nested AGF sub-PDU, then a length below two
        frm = '{8'h00, 8'h80, 8'h00, 8'h03, 8'h0B, 8'h45, 8'h3C,
                8'h00, 8'h02, 8'h00, 8'h80, 8'h00, 8'h01};
        send_frame();
        frm = '{8'h00, 8'h80, 8'h00};           // frame ends inside length
        send_frame();
        frm = '{8'h00, 8'h80, 8'hFF, 8'hFF};    // frame ends right after a big length
        send_frame();

        // Random phases, alternating the split setting
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_split(p[0]);
            goal = sent + PHASE_BYTES;
            while (sent < goal) begin
                build_frame();
                tx_fast = ($urandom_range(0, 5) == 0) || (p == 3);
                rx_fast = ($urandom_range(0, 5) == 0) || (p == 3);
                send_frame();
                // hold the sender once until the output side has drained
                if (p == 2 && !paused && sent + PHASE_BYTES / 2 >= goal) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        rx_fast = 1'b0;
        settle();
        if (n_bad == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
